### rtl/core/ihp_pkg.sv
// Package for the indexed ternary min-heap: sizes, command and status codes.
// Used by the channel interfaces, the RAM wrapper users and the top level.
`timescale 1ns / 1ps
package ihp_pkg;

  localparam int unsigned MaxElements = 1024;
  localparam int unsigned ElemW       = 10;
  localparam int unsigned CntW        = 11;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned ChildW      = 12;

  // (x - 1) / 3 for a 10 bit node index is (x - 1) * 683 >> 11.
  localparam int unsigned Div3Mul   = 683;
  localparam int unsigned Div3Shift = 11;
  localparam int unsigned Div3ProdW = 20;

  localparam logic [CntW-1:0] CapMax  = CntW'(MaxElements);
  localparam logic [KeyW-1:0] KeySign = {1'b1, {(KeyW-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_CHANGE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

### rtl/core/ihp_if.sv
// Valid/ready channel interfaces for the heap: command in, result out.
// Depends on ihp_pkg for field widths and codes.
`timescale 1ns / 1ps
interface ihp_req_if import ihp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  cmd_e                    cmd;
  logic [ElemW-1:0]        element;
  logic signed [KeyW-1:0]  key;

  modport source (output valid, cmd, element, key, input ready);
  modport sink   (input valid, cmd, element, key, output ready);
endinterface

interface ihp_rsp_if import ihp_pkg::*; ();
  logic             valid;
  logic             ready;
  status_e          status;
  logic [ElemW-1:0] popped_element;
  logic             min_valid;
  logic [ElemW-1:0] min_element;
  logic [CntW-1:0]  count;

  modport source (output valid, status, popped_element, min_valid, min_element, count,
                  input ready);
  modport sink   (input valid, status, popped_element, min_valid, min_element, count,
                  output ready);
endinterface

### rtl/core/ihp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ihp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/core/indexed_ternary_min_heap.sv
// Indexed ternary min-heap priority queue, top level and sequencer.
// Depends on ihp_pkg, ihp_req_if / ihp_rsp_if and three ihp_ram instances.
//
//   Channel   Direction  Handshake      Carries
//   req_i     in         valid/ready    cmd, element, key
//   rsp_o     out        valid/ready    status, popped_element, min_valid, min_element, count
//   cfg_*_i   in         write enable   capacity (11 bit)
//
// One command is worked at a time. A refused command (full or empty) goes straight to the
// finish states. A sift up works each level as a parent slot read, a parent key read, then a
// compare and write; a sift down works each level as a slot and a key read for each of up to
// three children through the single read port of each memory, then the decision. Reset
// clears the count and sets the capacity to its maximum; the memories need no clearing, as
// membership is always checked against the count. A stalled result sits in the output
// register while the next command is already worked.
`timescale 1ns / 1ps
module indexed_ternary_min_heap import ihp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  ihp_req_if.sink         req_i,
  ihp_rsp_if.source       rsp_o,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MEM1, S_MEM2, S_CK, S_POP, S_RM0, S_RM1, S_RM2,
    S_UP, S_UP1, S_UP2, S_DN, S_DN_HS, S_DN_KS, S_DN_DEC, S_FIN, S_FIN2
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]  cnt_q, cnt_d, cap_q;
  cmd_e             cmd_q, cmd_d;
  logic [ElemW-1:0] e_q, e_d;
  logic [KeyW-1:0]  bk_q, bk_d;          // key with sign bit flipped
  status_e          status_q, status_d;
  logic [ElemW-1:0] popped_q, popped_d;
  logic [ElemW-1:0] slot_q, slot_d;
  logic [ElemW-1:0] mv_e_q, mv_e_d;      // element being sifted
  logic [KeyW-1:0]  mv_k_q, mv_k_d;
  logic [ElemW-1:0] x_q, x_d;            // node the moving element is parked at
  logic [ElemW-1:0] par_q, par_d;
  logic [ElemW-1:0] ce_q, ce_d;          // element read out of a slot
  logic [KeyW-1:0]  rk_q, rk_d;          // key of the element being removed
  logic [ElemW-1:0] c_q, c_d;
  logic [CntW-1:0]  lastc_q, lastc_d;
  logic             hb_q, hb_d;
  logic [KeyW-1:0]  best_k_q, best_k_d;
  logic [ElemW-1:0] best_e_q, best_e_d, best_c_q, best_c_d;

  logic             rsp_valid_q, rsp_valid_d;
  status_e          o_status_q, o_status_d;
  logic [ElemW-1:0] o_popped_q, o_popped_d, o_min_q, o_min_d;
  logic             o_minv_q, o_minv_d;
  logic [CntW-1:0]  o_cnt_q, o_cnt_d;

  // Memory ports.
  logic             ks_we, hs_we, so_we;
  logic [ElemW-1:0] ks_wa, hs_wa, so_wa, ks_ra, hs_ra, so_ra;
  logic [KeyW-1:0]  ks_wd, ks_rd;
  logic [ElemW-1:0] hs_wd, so_wd, hs_rd, so_rd;

  ihp_ram #(.WIDTH(KeyW), .DEPTH(MaxElements)) u_key_ram (
    .clk_i, .we_i(ks_we), .waddr_i(ks_wa), .wdata_i(ks_wd), .raddr_i(ks_ra), .rdata_o(ks_rd)
  );
  ihp_ram #(.WIDTH(ElemW), .DEPTH(MaxElements)) u_slot_ram (
    .clk_i, .we_i(hs_we), .waddr_i(hs_wa), .wdata_i(hs_wd), .raddr_i(hs_ra), .rdata_o(hs_rd)
  );
  ihp_ram #(.WIDTH(ElemW), .DEPTH(MaxElements)) u_pos_ram (
    .clk_i, .we_i(so_we), .waddr_i(so_wa), .wdata_i(so_wd), .raddr_i(so_ra), .rdata_o(so_rd)
  );

  logic [CntW-1:0]      cap_eff, nxt_c, first_end;
  logic [Div3ProdW-1:0] div_prod;
  logic [ElemW-1:0]     parent;
  logic [ChildW-1:0]    first;
  logic                 member;

  assign cap_eff   = (cap_q > CapMax) ? CapMax : cap_q;
  assign div_prod  = Div3ProdW'(x_q - ElemW'(1)) * Div3ProdW'(Div3Mul);
  assign parent    = ElemW'(div_prod >> Div3Shift);
  assign first     = ChildW'(x_q) * ChildW'(3) + ChildW'(1);
  assign first_end = (first + ChildW'(3) > ChildW'(cnt_q)) ? cnt_q : CntW'(first + ChildW'(3));
  assign nxt_c     = CntW'(c_q) + CntW'(1);
  assign member    = ({1'b0, slot_q} < cnt_q) && (hs_rd == e_q);

  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = o_status_q;
  assign rsp_o.popped_element = o_popped_q;
  assign rsp_o.min_valid      = o_minv_q;
  assign rsp_o.min_element    = o_min_q;
  assign rsp_o.count          = o_cnt_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_d    = cmd_q;
    e_d      = e_q;
    bk_d     = bk_q;
    status_d = status_q;
    popped_d = popped_q;
    slot_d   = slot_q;
    mv_e_d   = mv_e_q;
    mv_k_d   = mv_k_q;
    x_d      = x_q;
    par_d    = par_q;
    ce_d     = ce_q;
    rk_d     = rk_q;
    c_d      = c_q;
    lastc_d  = lastc_q;
    hb_d     = hb_q;
    best_k_d = best_k_q;
    best_e_d = best_e_q;
    best_c_d = best_c_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    o_status_d  = o_status_q;
    o_popped_d  = o_popped_q;
    o_minv_d    = o_minv_q;
    o_min_d     = o_min_q;
    o_cnt_d     = o_cnt_q;
    ks_we = 1'b0; ks_wa = e_q;  ks_wd = bk_q; ks_ra = e_q;
    hs_we = 1'b0; hs_wa = x_q;  hs_wd = mv_e_q; hs_ra = '0;
    so_we = 1'b0; so_wa = mv_e_q; so_wd = x_q; so_ra = e_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d    = req_i.cmd;
          e_d      = req_i.element;
          bk_d     = req_i.key ^ KeySign;
          status_d = ST_DONE;
          popped_d = '0;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (cnt_q >= cap_eff) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              state_d = S_MEM1;
            end
          end
          CMD_POP: begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              state_d = S_POP;
            end
          end
          default: state_d = S_MEM1;
        endcase
      end
      S_MEM1: begin
        slot_d  = so_rd;
        hs_ra   = so_rd;
        state_d = S_MEM2;
      end
      S_MEM2: begin
        case (cmd_q)
          CMD_INSERT: begin
            if (member) begin
              state_d = S_FIN;
            end else begin
              ks_we   = 1'b1;
              cnt_d   = cnt_q + CntW'(1);
              mv_e_d  = e_q;
              mv_k_d  = bk_q;
              x_d     = cnt_q[ElemW-1:0];
              state_d = S_UP;
            end
          end
          CMD_DELETE: state_d = member ? S_RM0 : S_FIN;
          CMD_CHANGE: state_d = member ? S_CK : S_FIN;
          default:    state_d = S_FIN;
        endcase
      end
      S_CK: begin
        mv_e_d = e_q;
        mv_k_d = bk_q;
        x_d    = slot_q;
        if (bk_q < ks_rd) begin
          ks_we   = 1'b1;
          state_d = S_UP;
        end else if (ks_rd < bk_q) begin
          ks_we   = 1'b1;
          state_d = S_DN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_POP: begin
        popped_d = hs_rd;
        e_d      = hs_rd;
        slot_d   = '0;
        state_d  = S_RM0;
      end
      S_RM0: begin
        // The last slot fills the hole left by the removed element.
        cnt_d   = cnt_q - CntW'(1);
        hs_ra   = ElemW'(cnt_q - CntW'(1));
        state_d = S_RM1;
      end
      S_RM1: begin
        mv_e_d = hs_rd;
        rk_d   = ks_rd;
        x_d    = slot_q;
        ks_ra  = hs_rd;
        state_d = (hs_rd == e_q) ? S_FIN : S_RM2;
      end
      S_RM2: begin
        mv_k_d  = ks_rd;
        state_d = (ks_rd <= rk_q) ? S_UP : S_DN;
      end
      S_UP: begin
        if (x_q == '0) begin
          hs_we   = 1'b1;
          so_we   = 1'b1;
          state_d = S_FIN;
        end else begin
          hs_ra   = parent;
          par_d   = parent;
          state_d = S_UP1;
        end
      end
      S_UP1: begin
        ce_d    = hs_rd;
        ks_ra   = hs_rd;
        state_d = S_UP2;
      end
      S_UP2: begin
        hs_we = 1'b1;
        so_we = 1'b1;
        if (mv_k_q < ks_rd) begin
          hs_wd   = ce_q;
          so_wa   = ce_q;
          x_d     = par_q;
          state_d = S_UP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN: begin
        if (first >= ChildW'(cnt_q)) begin
          hs_we   = 1'b1;
          so_we   = 1'b1;
          state_d = S_FIN;
        end else begin
          c_d     = first[ElemW-1:0];
          lastc_d = first_end;
          hs_ra   = first[ElemW-1:0];
          hb_d    = 1'b0;
          state_d = S_DN_HS;
        end
      end
      S_DN_HS: begin
        ce_d    = hs_rd;
        ks_ra   = hs_rd;
        state_d = S_DN_KS;
      end
      S_DN_KS: begin
        // Strict less keeps the leftmost child on a tie.
        if (!hb_q || ks_rd < best_k_q) begin
          hb_d     = 1'b1;
          best_k_d = ks_rd;
          best_e_d = ce_q;
          best_c_d = c_q;
        end
        if (nxt_c < lastc_q) begin
          c_d     = nxt_c[ElemW-1:0];
          hs_ra   = nxt_c[ElemW-1:0];
          state_d = S_DN_HS;
        end else begin
          state_d = S_DN_DEC;
        end
      end
      S_DN_DEC: begin
        hs_we = 1'b1;
        so_we = 1'b1;
        if (best_k_q < mv_k_q) begin
          hs_wd   = best_e_q;
          so_wa   = best_e_q;
          x_d     = best_c_q;
          state_d = S_DN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        hs_ra   = '0;
        state_d = S_FIN2;
      end
      S_FIN2: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          o_status_d  = status_q;
          o_popped_d  = popped_q;
          o_minv_d    = (cnt_q != '0);
          o_min_d     = (cnt_q != '0) ? hs_rd : '0;
          o_cnt_d     = cnt_q;
          state_d     = S_IDLE;
        end else begin
          hs_ra = '0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cap_q       <= CapMax;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    e_q        <= e_d;
    bk_q       <= bk_d;
    status_q   <= status_d;
    popped_q   <= popped_d;
    slot_q     <= slot_d;
    mv_e_q     <= mv_e_d;
    mv_k_q     <= mv_k_d;
    x_q        <= x_d;
    par_q      <= par_d;
    ce_q       <= ce_d;
    rk_q       <= rk_d;
    c_q        <= c_d;
    lastc_q    <= lastc_d;
    hb_q       <= hb_d;
    best_k_q   <= best_k_d;
    best_e_q   <= best_e_d;
    best_c_q   <= best_c_d;
    o_status_q <= o_status_d;
    o_popped_q <= o_popped_d;
    o_minv_q   <= o_minv_d;
    o_min_q    <= o_min_d;
    o_cnt_q    <= o_cnt_d;
  end

endmodule
